FILE: rtl/core/pd4b5b_pkg.sv
// Shared types, line symbols and 4B5B helpers for the USB PD frame encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package pd4b5b_pkg;

    // Frame limits and chunking
    localparam int          MAX_PAYLOAD_BYTES = 30;
    localparam logic [3:0]  CHUNK_BITS        = 4'd10;
    localparam int          CODE_W            = 40;
    localparam int          STREAM_W          = 96;

    // Queue between front and back
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = 2;
    localparam int          QCNT_W      = 3;

    // Command codes as carried on tuser
    typedef enum logic [1:0] {
        CMD_SOP  = 2'd0,
        CMD_HRST = 2'd1,
        CMD_BYTE = 2'd2,
        CMD_END  = 2'd3
    } t_cmd;

    // One classified command waiting for the back end
    typedef struct packed {
        t_cmd               kind;
        logic [CODE_W-1:0]  code;
    } t_entry;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic nonempty;
        logic full;
    } t_q_status;

    // Special K-code symbols, sent LSB first
    localparam logic [4:0] SYM_SYNC1 = 5'h18;
    localparam logic [4:0] SYM_SYNC2 = 5'h11;
    localparam logic [4:0] SYM_RST1  = 5'h07;
    localparam logic [4:0] SYM_RST2  = 5'h19;
    localparam logic [4:0] SYM_EOP   = 5'h0D;

    // Alternating preamble, a zero on the line first
    localparam logic [63:0] PREAMBLE = {32{2'b10}};

    // Fixed bit streams of the ordered sets, padding bits are zero
    localparam logic [STREAM_W-1:0] SOP_STREAM =
        {12'd0, SYM_SYNC2, SYM_SYNC1, SYM_SYNC1, SYM_SYNC1, PREAMBLE};
    localparam logic [STREAM_W-1:0] HRST_STREAM =
        {12'd0, SYM_RST2, SYM_RST1, SYM_RST1, SYM_RST1, PREAMBLE};

    // Standard 4B5B data symbol table
    function automatic logic [4:0] enc4b5b(input logic [3:0] nib);
        logic [4:0] sym;
        case (nib)
            4'h0: sym = 5'h1E;
            4'h1: sym = 5'h09;
            4'h2: sym = 5'h14;
            4'h3: sym = 5'h15;
            4'h4: sym = 5'h0A;
            4'h5: sym = 5'h0B;
            4'h6: sym = 5'h0E;
            4'h7: sym = 5'h0F;
            4'h8: sym = 5'h12;
            4'h9: sym = 5'h13;
            4'hA: sym = 5'h16;
            4'hB: sym = 5'h17;
            4'hC: sym = 5'h1A;
            4'hD: sym = 5'h1B;
            4'hE: sym = 5'h1C;
            default: sym = 5'h1D;
        endcase
        return sym;
    endfunction

    // Index of the final chunk of each command
    function automatic logic [3:0] last_chunk(input t_cmd kind);
        logic [3:0] idx;
        case (kind)
            CMD_SOP:  idx = 4'd8;
            CMD_HRST: idx = 4'd8;
            CMD_BYTE: idx = 4'd0;
            CMD_END:  idx = 4'd4;
            default:  idx = 4'd0;
        endcase
        return idx;
    endfunction

    // Number of bits in the final chunk of each command
    function automatic logic [3:0] last_count(input t_cmd kind);
        logic [3:0] cnt;
        case (kind)
            CMD_SOP:  cnt = 4'd4;
            CMD_HRST: cnt = 4'd6;
            CMD_BYTE: cnt = CHUNK_BITS;
            CMD_END:  cnt = 4'd7;
            default:  cnt = CHUNK_BITS;
        endcase
        return cnt;
    endfunction

endpackage

FILE: rtl/core/pd4b5b_front.sv
// Front end: accepts commands, tracks the open frame and encodes data symbols.
// Depends on pd4b5b_pkg; pushes classified entries into pd4b5b_queue.
module pd4b5b_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_cmd,
    input  logic [7:0]            i_data_byte,
    input  logic [31:0]           i_crc_value,
    input  pd4b5b_pkg::t_q_status i_q_status,
    output logic                  o_push,
    output pd4b5b_pkg::t_entry    o_entry
);

    logic       r_open;
    logic       n_open;
    logic [4:0] r_count;
    logic [4:0] n_count;
    logic       accept;
    logic       room;
    pd4b5b_pkg::t_cmd cmd;
    logic [pd4b5b_pkg::CODE_W-1:0] crc_code;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign cmd     = pd4b5b_pkg::t_cmd'(i_cmd);
    assign room    = r_count < 5'(pd4b5b_pkg::MAX_PAYLOAD_BYTES);

    // Eight CRC nibbles, low nibble first, each five bits on the line
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            crc_code[i*5 +: 5] = pd4b5b_pkg::enc4b5b(i_crc_value[i*4 +: 4]);
        end
    end

    // Classify the command, decide whether it makes any output
    always_comb begin
        n_open        = r_open;
        n_count       = r_count;
        o_push        = 1'b0;
        o_entry.kind  = cmd;
        o_entry.code  = crc_code;
        case (cmd)
            pd4b5b_pkg::CMD_SOP: begin
                o_push  = accept;
                if (accept) begin
                    n_open  = 1'b1;
                    n_count = 5'd0;
                end
            end
            pd4b5b_pkg::CMD_HRST: begin
                o_push  = accept;
                if (accept) begin
                    n_open  = 1'b0;
                    n_count = 5'd0;
                end
            end
            pd4b5b_pkg::CMD_BYTE: begin
                o_entry.code = {30'd0, pd4b5b_pkg::enc4b5b(i_data_byte[7:4]),
                                pd4b5b_pkg::enc4b5b(i_data_byte[3:0])};
                o_push = accept && r_open && room;
                if (o_push) begin
                    n_count = r_count + 5'd1;
                end
            end
            pd4b5b_pkg::CMD_END: begin
                o_push = accept && r_open;
                if (o_push) begin
                    n_open  = 1'b0;
                    n_count = 5'd0;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_count <= 5'd0;
        end else begin
            r_open  <= n_open;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/core/pd4b5b_queue.sv
// Short queue of classified commands between the front and the back end.
// Depends on pd4b5b_pkg for the entry type and the depth.
module pd4b5b_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pd4b5b_pkg::t_entry    i_entry,
    input  logic                  i_pop,
    output pd4b5b_pkg::t_entry    o_head,
    output pd4b5b_pkg::t_q_status o_status
);

    pd4b5b_pkg::t_entry r_mem [pd4b5b_pkg::QUEUE_DEPTH];
    logic [pd4b5b_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [pd4b5b_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [pd4b5b_pkg::QCNT_W-1:0] r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.nonempty = r_count != '0;
    assign o_status.full   = r_count == pd4b5b_pkg::QCNT_W'(pd4b5b_pkg::QUEUE_DEPTH);

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/pd4b5b_back.sv
// Back end: cuts the head command's bit stream into chunks of up to 10 bits.
// Depends on pd4b5b_pkg; drives the output register of the master stream.
module pd4b5b_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pd4b5b_pkg::t_entry    i_head,
    input  pd4b5b_pkg::t_q_status i_q_status,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [9:0]            o_line_bits,
    output logic [3:0]            o_bit_count,
    output logic                  o_last
);

    logic [3:0] r_idx;
    logic       r_valid;
    logic [9:0] r_bits;
    logic [3:0] r_cnt;
    logic       r_last;
    logic       load;
    logic       is_last;
    logic [6:0] base;
    logic [pd4b5b_pkg::STREAM_W-1:0] stream;

    // Whole bit stream of the head command
    always_comb begin
        case (i_head.kind)
            pd4b5b_pkg::CMD_SOP:  stream = pd4b5b_pkg::SOP_STREAM;
            pd4b5b_pkg::CMD_HRST: stream = pd4b5b_pkg::HRST_STREAM;
            pd4b5b_pkg::CMD_BYTE: stream = {86'd0, i_head.code[9:0]};
            pd4b5b_pkg::CMD_END:  stream = {51'd0, pd4b5b_pkg::SYM_EOP, i_head.code};
            default:              stream = '0;
        endcase
    end

    // Chunk selection: base is ten times the chunk index
    assign base    = {r_idx, 3'b000} + {2'b00, r_idx, 1'b0};
    assign is_last = r_idx == pd4b5b_pkg::last_chunk(i_head.kind);
    assign load    = i_q_status.nonempty && (!r_valid || i_ready);
    assign o_pop   = load && is_last;

    // Chunk index within the head command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= is_last ? 4'd0 : r_idx + 4'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bits <= stream[base +: 10];
            r_cnt  <= is_last ? pd4b5b_pkg::last_count(i_head.kind)
                              : pd4b5b_pkg::CHUNK_BITS;
            r_last <= is_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_line_bits = r_bits;
    assign o_bit_count = r_cnt;
    assign o_last      = r_last;

endmodule

FILE: rtl/core/usb_pd_4b5b_frame_encoder.sv
// Top level of the USB PD 4B5B frame encoder.
// Depends on pd4b5b_pkg, pd4b5b_front, pd4b5b_queue and pd4b5b_back.
//
// Usage:
//   The slave stream takes one command per beat: tuser carries the command
//   (start, hard reset, payload byte, end), tdata the byte and the CRC.
//   The master stream returns the line bits before BMC coding in chunks of
//   up to 10 bits, bit 0 first; tlast marks the final chunk of a command.
//   A start or hard reset yields 9 beats, a payload byte 1 and an end 5.
//   Payload or end outside an open frame, and bytes past the payload
//   limit, yield no beat at all.
//   The first chunk of a command is registered into the queue and then into
//   the output register before it is valid. Throughput is one output beat
//   per cycle while the receiver holds tready high, set by the single chunk
//   selector of the back end, so payload bytes are taken at one per cycle
//   and a longer command holds the selector for all of its beats.
//   A four-entry command queue separates the front and back ends; the front
//   keeps accepting while the queue has room, even while the receiver holds
//   tready low and the output register waits.
//   Reset clears the frame state, the queue and the output valid.
module usb_pd_4b5b_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] crc_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] line_bits, [13:10] bit_count, zero above
    output logic        m_axis_tlast    // last
);

    pd4b5b_pkg::t_q_status q_status;
    pd4b5b_pkg::t_entry    push_entry;
    pd4b5b_pkg::t_entry    head;
    logic                  push;
    logic                  pop;
    logic [9:0]            line_bits;
    logic [3:0]            bit_count;

    pd4b5b_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_data_byte (s_axis_tdata[7:0]),
        .i_crc_value (s_axis_tdata[39:8]),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    pd4b5b_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    pd4b5b_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_line_bits (line_bits),
        .o_bit_count (bit_count),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, bit_count, line_bits};

`ifndef SYNTHESIS
    // Every delivered chunk carries between one and ten bits.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:10] != 4'd0 && m_axis_tdata[13:10] <= 4'd10))
        else $error("chunk bit count out of range");

    // Only the final chunk of a command may be short.
    a_full_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tdata[13:10] == 4'd10)
        else $error("short chunk before the end of a command");

    // The queue is never written while it is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!q_status.full || pop))
        else $error("command queue overflow");

    // Nothing is shown on the master side right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

FILE: sim/usb_pd_4b5b_frame_encoder_tb.sv
// Self-checking testbench for the USB PD 4B5B frame encoder.
// Depends on pd4b5b_pkg and usb_pd_4b5b_frame_encoder; reads no files.
// A directed table runs first, then random frames, each beat checked in order.
module usb_pd_4b5b_frame_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 470;
    localparam int DRAIN_CYCLES  = 40;
    localparam int MAX_PRINTS    = 40;

    // Data symbols of the 4B5B code, indexed by nibble
    localparam logic [4:0] NIB_CODE [16] = '{
        5'h1E, 5'h09, 5'h14, 5'h15, 5'h0A, 5'h0B, 5'h0E, 5'h0F,
        5'h12, 5'h13, 5'h16, 5'h17, 5'h1A, 5'h1B, 5'h1C, 5'h1D
    };

    // One chunk of line bits as it leaves the block
    typedef struct {
        logic [9:0] bits;
        logic [3:0] count;
        logic       last;
    } t_chunk;

    // One row of the directed table; pinned rows carry their beat typed in
    typedef struct {
        pd4b5b_pkg::t_cmd cmd;
        logic [7:0]       data_v;
        logic [31:0]      crc;
        bit               pinned;
        bit               pinned_beat;
        logic [15:0]      pinned_tdata;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // [7:0] data_byte, [39:8] crc_value
    logic [1:0]  s_axis_tuser;    // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [9:0] line_bits, [13:10] bit_count, zero above
    logic        m_axis_tlast;    // last

    // Encoder state as the testbench tracks it
    logic        frame_live;
    logic [4:0]  bytes_in_frame;
    logic [95:0] line_stream;
    int          line_len;

    t_chunk      chunk_buf[$];
    t_chunk      pending_chunks[$];
    t_row        dir_rows [24];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          items_counted = 0;

    int          rx_mode = 0;
    int          rx_mode_left = 0;
    int          rx_phase = 0;

    usb_pd_4b5b_frame_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Appends one 5-bit symbol, least significant bit first.
    function automatic void append_symbol(input logic [4:0] sym);
        for (int i = 0; i < 5; i++) begin
            line_stream[line_len + i] = sym[i];
        end
        line_len += 5;
    endfunction

    // Works out the chunks that one command causes and updates the frame state.
    function automatic int predict_line_chunks(input pd4b5b_pkg::t_cmd c,
                                               input logic [7:0] d,
                                               input logic [31:0] crc);
        int     pos;
        int     cnt;
        t_chunk ch;
        chunk_buf.delete();
        line_stream = '0;
        line_len = 0;
        case (c)
            pd4b5b_pkg::CMD_SOP, pd4b5b_pkg::CMD_HRST: begin
                for (int i = 0; i < 64; i++) begin
                    line_stream[i] = i[0];
                end
                line_len = 64;
                if (c == pd4b5b_pkg::CMD_SOP) begin
                    append_symbol(pd4b5b_pkg::SYM_SYNC1);
                    append_symbol(pd4b5b_pkg::SYM_SYNC1);
                    append_symbol(pd4b5b_pkg::SYM_SYNC1);
                    append_symbol(pd4b5b_pkg::SYM_SYNC2);
                    frame_live = 1'b1;
                end else begin
                    append_symbol(pd4b5b_pkg::SYM_RST1);
                    append_symbol(pd4b5b_pkg::SYM_RST1);
                    append_symbol(pd4b5b_pkg::SYM_RST1);
                    append_symbol(pd4b5b_pkg::SYM_RST2);
                    line_len += 2;
                    frame_live = 1'b0;
                end
                bytes_in_frame = '0;
            end
            pd4b5b_pkg::CMD_BYTE: begin
                if (!frame_live || bytes_in_frame >= pd4b5b_pkg::MAX_PAYLOAD_BYTES) begin
                    return 0;
                end
                append_symbol(NIB_CODE[d[3:0]]);
                append_symbol(NIB_CODE[d[7:4]]);
                bytes_in_frame = bytes_in_frame + 5'd1;
            end
            default: begin
                if (!frame_live) begin
                    return 0;
                end
                for (int i = 0; i < 8; i++) begin
                    append_symbol(NIB_CODE[crc[4*i +: 4]]);
                end
                append_symbol(pd4b5b_pkg::SYM_EOP);
                line_len += 2;
                frame_live = 1'b0;
                bytes_in_frame = '0;
            end
        endcase
        // Cut the stream into 10-bit chunks; only the final one may be short.
        pos = 0;
        while (pos < line_len) begin
            cnt = (line_len - pos > 10) ? 10 : line_len - pos;
            ch.bits = '0;
            for (int i = 0; i < cnt; i++) begin
                ch.bits[i] = line_stream[pos + i];
            end
            ch.count = cnt[3:0];
            pos += cnt;
            ch.last = (pos >= line_len);
            chunk_buf.push_back(ch);
        end
        return chunk_buf.size();
    endfunction

    // Presents one command beat in bursts with random gaps, then predicts it.
    task automatic drive_command(input pd4b5b_pkg::t_cmd c, input logic [7:0] d,
                                 input logic [31:0] crc,
                                 input bit pinned, input bit pinned_beat,
                                 input logic [15:0] pinned_td);
        int     gap;
        int     n;
        t_chunk ch;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= {$urandom, 8'($urandom_range(0, 255))};
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= {crc, d};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        n = predict_line_chunks(c, d, crc);
        if (n > 0) begin
            items_counted++;
        end
        if (pinned) begin
            if (pinned_beat) begin
                ch.bits  = pinned_td[9:0];
                ch.count = pinned_td[13:10];
                ch.last  = 1'b1;
                pending_chunks.push_back(ch);
            end
        end else begin
            foreach (chunk_buf[i]) begin
                pending_chunks.push_back(chunk_buf[i]);
            end
        end
    endtask

    // Receiver readiness: always ready, random, periodic or mostly stalled.
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(32, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 9) < 7);
            2: m_axis_tready <= ((rx_phase % 5) < 3);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compares every output beat with the oldest expected chunk.
    always @(posedge i_clk) begin
        t_chunk want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chunks.size() == 0) begin
                report_mismatch($sformatf("unexpected beat tdata=%h tlast=%b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                want = pending_chunks.pop_front();
                if (m_axis_tdata[9:0] !== want.bits || m_axis_tdata[13:10] !== want.count ||
                    m_axis_tlast !== want.last || m_axis_tdata[15:14] !== 2'b00) begin
                    report_mismatch($sformatf(
                        "bits %h/%h count %0d/%0d last %b/%b pad %b (got/want)",
                        m_axis_tdata[9:0], want.bits, m_axis_tdata[13:10], want.count,
                        m_axis_tlast, want.last, m_axis_tdata[15:14]));
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("usb_pd_4b5b_frame_encoder: mismatch");
            $finish;
        end
    end

    // Reset, directed table, random frames, drain and verdict.
    initial begin
        int kind;
        int nbytes;
        int frame_idx;
        pd4b5b_pkg::t_cmd rc;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= pd4b5b_pkg::CMD_SOP;
        s_axis_tdata  <= '0;
        frame_live     = 1'b0;
        bytes_in_frame = '0;

        dir_rows = '{
            // Byte after reset
            '{pd4b5b_pkg::CMD_BYTE, 8'h5A, 32'h0000_0000, 1'b1, 1'b0, 16'h0000},
            // End after reset
            '{pd4b5b_pkg::CMD_END,  8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_SOP,  8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000},
            // End with no payload
            '{pd4b5b_pkg::CMD_END,  8'h00, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            // End with the frame closed
            '{pd4b5b_pkg::CMD_END,  8'h00, 32'h1234_5678, 1'b1, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_HRST, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            // Byte after hard reset
            '{pd4b5b_pkg::CMD_BYTE, 8'hFF, 32'h0000_0000, 1'b1, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_SOP,  8'h00, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            // Lowest byte
            '{pd4b5b_pkg::CMD_BYTE, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h2BDE},
            // Highest byte
            '{pd4b5b_pkg::CMD_BYTE, 8'hFF, 32'h0000_0000, 1'b1, 1'b1, 16'h2BBD},
            '{pd4b5b_pkg::CMD_BYTE, 8'h10, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_BYTE, 8'h32, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_BYTE, 8'h54, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_BYTE, 8'h76, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_BYTE, 8'h98, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_BYTE, 8'hBA, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_BYTE, 8'hDC, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_BYTE, 8'hFE, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            // Restart of an open frame
            '{pd4b5b_pkg::CMD_SOP,  8'h00, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_BYTE, 8'hA5, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_END,  8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000},
            '{pd4b5b_pkg::CMD_SOP,  8'h00, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
            // Hard reset inside a frame
            '{pd4b5b_pkg::CMD_HRST, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000},
            // End after hard reset
            '{pd4b5b_pkg::CMD_END,  8'h00, 32'h89AB_CDEF, 1'b1, 1'b0, 16'h0000}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            drive_command(dir_rows[i].cmd, dir_rows[i].data_v, dir_rows[i].crc,
                          dir_rows[i].pinned, dir_rows[i].pinned_beat,
                          dir_rows[i].pinned_tdata);
        end

        // Random part: mostly whole frames, some overfilled, broken or stray commands.
        items_counted = 0;
        frame_idx = 0;
        while (items_counted < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                rc = pd4b5b_pkg::t_cmd'($urandom_range(0, 3));
                drive_command(rc, 8'($urandom_range(0, 255)), $urandom, 1'b0, 1'b0, '0);
            end else begin
                frame_idx++;
                nbytes = (frame_idx % 8 == 1) ? $urandom_range(29, 34)
                                               : $urandom_range(0, 10);
                drive_command(pd4b5b_pkg::CMD_SOP, 8'($urandom_range(0, 255)), $urandom,
                              1'b0, 1'b0, '0);
                for (int b = 0; b < nbytes; b++) begin
                    drive_command(pd4b5b_pkg::CMD_BYTE, 8'($urandom_range(0, 255)),
                                  $urandom, 1'b0, 1'b0, '0);
                end
                if (kind < 5) begin
                    // Broken frame: abandoned by a new start or a hard reset.
                    rc = ($urandom_range(0, 1) == 0) ? pd4b5b_pkg::CMD_SOP
                                                     : pd4b5b_pkg::CMD_HRST;
                    drive_command(rc, 8'($urandom_range(0, 255)), $urandom, 1'b0, 1'b0, '0);
                end else begin
                    drive_command(pd4b5b_pkg::CMD_END, 8'($urandom_range(0, 255)),
                                  $urandom, 1'b0, 1'b0, '0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Wait for every expected beat, then a little longer for strays.
        while (pending_chunks.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_chunks.size() == 0) begin
            $display("usb_pd_4b5b_frame_encoder: match");
        end else begin
            $display("usb_pd_4b5b_frame_encoder: mismatch");
        end
        $finish;
    end

endmodule
